[sv/pba_pkg.sv]
package pba_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC_LOW  = 2'd0,
		OP_ALLOC_NEXT = 2'd1,
		OP_RESERVE    = 2'd2,
		OP_RELEASE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_BUSY    = 3'd2,
		ST_RANGE   = 3'd3,
		ST_NOTHELD = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OPEN,
		S_READ,
		S_MODIFY,
		S_SHRINK_RD,
		S_SHRINK_CHK,
		S_DONE
	} fsm_t;

	localparam int ReqIdW = 12;
	localparam int GrantW = 10;

endpackage

[sv/pba_ram.sv]
module pba_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/pba_search.sv]
// lowest clear bit at or above a start position, and lowest clear bit overall
module pba_search #(
	parameter int PoolBits = 32
) (
	input  logic [PoolBits-1:0]         word,
	input  logic [$clog2(PoolBits):0]   start,
	output logic                        hit_hi,
	output logic [$clog2(PoolBits)-1:0] idx_hi,
	output logic                        hit_lo,
	output logic [$clog2(PoolBits)-1:0] idx_lo
);
	localparam int BW = $clog2(PoolBits);

	always_comb begin
		hit_hi = 1'b0;
		idx_hi = '0;
		hit_lo = 1'b0;
		idx_lo = '0;
		for (int i = PoolBits - 1; i >= 0; i--) begin
			if (!word[i]) begin
				hit_lo = 1'b1;
				idx_lo = BW'(i);
				if ((BW + 1)'(i) >= start) begin
					hit_hi = 1'b1;
					idx_hi = BW'(i);
				end
			end
		end
	end
endmodule

[sv/pooled_bitmap_id_allocator_core.sv]
// pooled bitmap id allocator
// input channel: in_valid / in_stall with operation and req_id; the block
// raises in_stall while it works on an item and while its result waits.
// output channel: out_valid / out_stall with granted_id and status, one
// result per item, held in an output register until taken.
// operations: allocate lowest, allocate next-fit, reserve, release.
// an item that touches a pool word goes through S_READ (ram read), S_MODIFY
// (search and write back) and S_DONE before its result is valid. an item
// settled at once (out of range, space full, release above the open pools)
// goes straight to S_DONE. opening a pool adds an S_OPEN step per pool
// opened, and a release that frees the tail pool adds an S_SHRINK_RD and
// S_SHRINK_CHK pair per tail pool examined: each one closed and the one that
// stops the scan. the next item is accepted the cycle after the result is
// taken; the block takes no new item while one is in work or waiting.
// the pool words, free counts and hints live in one synchronous ram with a
// registered read port; only the open pool count and the nonfull mask
// are in flip-flops.
// reset clears the open pool count and nonfull mask; no clearing pass is
// needed since a pool's entry is written when it is opened.
// while the receiver stalls the result holds and in_stall stays high.
module pooled_bitmap_id_allocator_core #(
	parameter int POOL_BITS = 32,
	parameter int MAX_IDS   = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic [pba_pkg::ReqIdW-1:0] req_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [pba_pkg::GrantW-1:0] granted_id,
	output logic [2:0]                status
);
	import pba_pkg::*;

	localparam int NumPools = MAX_IDS / POOL_BITS;
	localparam int IdLimit  = NumPools * POOL_BITS;
	localparam int BW       = $clog2(POOL_BITS);
	localparam int PW       = (NumPools > 1) ? $clog2(NumPools) : 1;
	localparam int CW       = $clog2(NumPools + 1);
	localparam int FW       = BW + 1;
	localparam int EW       = POOL_BITS + 2 * FW;

	fsm_t state_q, state_d;

	logic [1:0]        op_q;
	logic [PW-1:0]     pool_q;
	logic [BW-1:0]     bit_q;
	logic [CW-1:0]     open_q;
	logic [NumPools-1:0] nonfull_q;
	logic              out_valid_q;
	logic [GrantW-1:0] grant_q;
	logic [2:0]        status_q;

	// ram entry: {hint, free count, word}
	logic          ram_we;
	logic [PW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	pba_ram #(.Width(EW), .Depth(NumPools)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	logic [POOL_BITS-1:0] rd_word;
	logic [FW-1:0]        rd_free, rd_hint;
	assign rd_word = ram_rdata[POOL_BITS-1:0];
	assign rd_free = ram_rdata[POOL_BITS +: FW];
	assign rd_hint = ram_rdata[POOL_BITS + FW +: FW];

	logic          hit_hi, hit_lo;
	logic [BW-1:0] idx_hi, idx_lo;

	pba_search #(.PoolBits(POOL_BITS)) u_search (
		.word  (rd_word),
		.start (rd_hint),
		.hit_hi(hit_hi),
		.idx_hi(idx_hi),
		.hit_lo(hit_lo),
		.idx_lo(idx_lo)
	);

	// pool choice for allocations
	logic          lo_found;
	logic [PW-1:0] lo_pool, hi_pool;
	always_comb begin
		lo_found = 1'b0;
		lo_pool  = '0;
		hi_pool  = '0;
		for (int i = 0; i < NumPools; i++) begin
			if (nonfull_q[i]) begin
				hi_pool  = PW'(i);
			end
		end
		for (int i = NumPools - 1; i >= 0; i--) begin
			if (nonfull_q[i]) begin
				lo_found = 1'b1;
				lo_pool  = PW'(i);
			end
		end
	end

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign in_stall = (state_q != S_IDLE) || out_valid_q;

	logic req_in_range;
	assign req_in_range = 32'(req_id) < IdLimit;

	logic bit_held;
	assign bit_held = rd_word[bit_q];

	logic          pick_hit;
	logic [BW-1:0] pick_bit;
	always_comb begin
		if (op_q == OP_ALLOC_NEXT) begin
			pick_hit = hit_hi || hit_lo;
			pick_bit = hit_hi ? idx_hi : idx_lo;
		end else begin
			pick_hit = hit_lo;
			pick_bit = idx_lo;
		end
	end

	logic need_open;
	assign need_open = (CW'(pool_q) >= open_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (operation == OP_ALLOC_LOW || operation == OP_ALLOC_NEXT) begin
						if (!lo_found) begin
							state_d = (open_q >= CW'(NumPools)) ? S_DONE : S_OPEN;
						end else begin
							state_d = S_READ;
						end
					end else if (!req_in_range) begin
						state_d = S_DONE;
					end else if (operation == OP_RESERVE
						&& CW'(req_id[ReqIdW-1:BW]) >= open_q) begin
						state_d = S_OPEN;
					end else if (operation == OP_RELEASE
						&& CW'(req_id[ReqIdW-1:BW]) >= open_q) begin
						state_d = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_OPEN: begin
				if (CW'(pool_q) + CW'(1) == open_q + CW'(1)) state_d = S_READ;
			end
			S_READ:       state_d = S_MODIFY;
			S_MODIFY: begin
				if (op_q == OP_RELEASE && bit_held && rd_free + FW'(1) == FW'(POOL_BITS)
					&& CW'(pool_q) + CW'(1) == open_q) begin
					state_d = S_SHRINK_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHRINK_RD:  state_d = (open_q == '0) ? S_DONE : S_SHRINK_CHK;
			S_SHRINK_CHK: begin
				if (rd_free != FW'(POOL_BITS)) state_d = S_DONE;
				else if (open_q == CW'(1)) state_d = S_DONE;
				else state_d = S_SHRINK_RD;
			end
			S_DONE:       state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// ram control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pool_q;
		ram_wdata = '0;
		ram_raddr = pool_q;
		case (state_q)
			S_OPEN: begin
				ram_we    = 1'b1;
				ram_waddr = PW'(open_q);
				ram_wdata = {FW'(0), FW'(POOL_BITS), {POOL_BITS{1'b0}}};
			end
			S_MODIFY: begin
				if (op_q == OP_RELEASE) begin
					ram_we    = bit_held;
					ram_wdata = {rd_hint, rd_free + FW'(1),
						rd_word & ~(POOL_BITS'(1) << bit_q)};
				end else if (op_q == OP_RESERVE) begin
					ram_we    = !bit_held;
					ram_wdata = {FW'(bit_q) + FW'(1),
						(rd_free != '0) ? rd_free - FW'(1) : rd_free,
						rd_word | (POOL_BITS'(1) << bit_q)};
				end else begin
					ram_we    = pick_hit;
					ram_wdata = {FW'(pick_bit) + FW'(1),
						(rd_free != '0) ? rd_free - FW'(1) : rd_free,
						rd_word | (POOL_BITS'(1) << pick_bit)};
				end
			end
			S_SHRINK_RD: ram_raddr = PW'(open_q - CW'(1));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			open_q      <= '0;
			nonfull_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_acc) out_valid_q <= 1'b0;
			case (state_q)
				S_OPEN: begin
					nonfull_q[PW'(open_q)] <= 1'b1;
					open_q <= open_q + CW'(1);
				end
				S_MODIFY: begin
					if (op_q == OP_RELEASE) begin
						if (bit_held) nonfull_q[pool_q] <= 1'b1;
					end else if (op_q == OP_RESERVE) begin
						if (!bit_held && rd_free <= FW'(1)) nonfull_q[pool_q] <= 1'b0;
					end else if (pick_hit && rd_free <= FW'(1)) begin
						nonfull_q[pool_q] <= 1'b0;
					end
				end
				S_SHRINK_CHK: begin
					if (rd_free == FW'(POOL_BITS)) begin
						nonfull_q[PW'(open_q - CW'(1))] <= 1'b0;
						open_q <= open_q - CW'(1);
					end
				end
				S_DONE: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= operation;
			bit_q    <= req_id[BW-1:0];
			grant_q  <= '0;
			if (operation == OP_ALLOC_LOW || operation == OP_ALLOC_NEXT) begin
				pool_q   <= lo_found ? ((operation == OP_ALLOC_LOW) ? lo_pool : hi_pool)
					: PW'(open_q);
				status_q <= lo_found ? ST_OK : ST_FULL;
			end else begin
				pool_q   <= PW'(req_id[ReqIdW-1:BW]);
				status_q <= !req_in_range ? ST_RANGE
					: (operation == OP_RELEASE
						&& CW'(req_id[ReqIdW-1:BW]) >= open_q) ? ST_NOTHELD : ST_OK;
			end
		end else if (state_q == S_OPEN && need_open) begin
			status_q <= ST_OK;
		end else if (state_q == S_MODIFY) begin
			if (op_q == OP_RELEASE) begin
				status_q <= bit_held ? ST_OK : ST_NOTHELD;
			end else if (op_q == OP_RESERVE) begin
				status_q <= bit_held ? ST_BUSY : ST_OK;
				grant_q  <= bit_held ? '0 : GrantW'({pool_q, bit_q});
			end else begin
				status_q <= pick_hit ? ST_OK : ST_FULL;
				grant_q  <= pick_hit ? GrantW'({pool_q, pick_bit}) : '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign granted_id = grant_q;
	assign status     = status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(status_q))
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= CW'(NumPools))
		else $error("open pool count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> grant_q == '0)
		else $error("nonzero id on error status");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OPEN |=> open_q == $past(open_q) + CW'(1))
		else $error("pool open did not advance count");
endmodule
